>>> design/itoa_pkg.sv
// Package for the radix integer-to-ASCII converter.
// Holds the fixed field widths, character constants and small helper functions.
// Depends on nothing; the interfaces, the top level, the front end and the back end import it.
`default_nettype none

package itoa_pkg;

  // Fixed field widths of the channels and the radix register.
  localparam int IN_W    = 32;
  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;

  // Radix limits and reset value.
  localparam int RADIX_MIN   = 2;
  localparam int RADIX_MAX   = 36;
  localparam int RADIX_RESET = 10;

  // Character mapping constants.
  localparam int ASCII_ZERO = 48;
  localparam int ASCII_A    = 65;
  localparam int DECIMAL    = 10;

  // Dividend bits retired per cycle by the restoring divider.
  localparam int DIV_STEPS = 8;

  // Front-end converter states.
  typedef enum logic {
    ST_IDLE,
    ST_DIVIDE
  } front_state_t;

  // Clamp the programmed radix into the supported range.
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_W'(RADIX_MIN)) begin
      res = RADIX_W'(RADIX_MIN);
    end else if (r > RADIX_W'(RADIX_MAX)) begin
      res = RADIX_W'(RADIX_MAX);
    end else begin
      res = r;
    end
    return res;
  endfunction

  // Map a digit value to its uppercase ASCII character.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d >= DIGIT_W'(DECIMAL)) begin
      res = CHAR_W'(d) + CHAR_W'(ASCII_A - DECIMAL);
    end else begin
      res = CHAR_W'(d) + CHAR_W'(ASCII_ZERO);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> design/itoa_value_if.sv
// Input channel carrying one word to convert.
// Depends on itoa_pkg for the word width.
`default_nettype none

interface itoa_value_if import itoa_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

>>> design/itoa_char_if.sv
// Output channel carrying one ASCII character and its last-character flag.
// Depends on itoa_pkg for the character width.
`default_nettype none

interface itoa_char_if import itoa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink (input valid, input character, input last_char, output ready);
endinterface

`default_nettype wire

>>> design/radix_integer_to_ascii.sv
// Top level of the radix integer-to-ASCII converter.
// Depends on itoa_pkg, itoa_value_if, itoa_char_if, itoa_ram, itoa_front,
// itoa_queue and itoa_back.
//
//   Port      Kind       Payload                          Handshake
//   number    sink       value[31:0] unsigned word        valid/ready
//   text      source     character[6:0], last_char        valid/ready
//   radix_*   register   radix_wr_data[5:0] (reset 10)    radix_wr_en
//
// The converter takes a word, then works out each digit, least significant
// first, in an 8-step restoring divider. The emitter reads each digit from
// the RAM, then loads its character into the output register, and starts no
// new read while one is pending or the register is still held. Two RAM banks
// let one word convert while the previous one is emitted. Reset is synchronous
// and clears control state only; the digit RAM needs no clearing.
`default_nettype none

module radix_integer_to_ascii import itoa_pkg::*; #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               radix_wr_en,
  input  logic [RADIX_W-1:0] radix_wr_data,
  itoa_value_if.sink         number,
  itoa_char_if.source        text
);

  localparam int IDX_W  = $clog2(MAX_DIGITS);
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W = IDX_W + 1;
  localparam int DEPTH  = 2 * (2 ** IDX_W);

  logic [RADIX_W-1:0] radix;
  logic               push;
  logic [CNT_W-1:0]   push_count;
  logic               pop;
  logic [CNT_W-1:0]   head_count;
  logic               q_nonempty;
  logic               q_full;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [DIGIT_W-1:0] wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [DIGIT_W-1:0] rd_data;

  // Radix configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_W'(RADIX_RESET);
    end else if (radix_wr_en) begin
      radix <= radix_wr_data;
    end
  end

  // Digit conversion.
  itoa_front #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .number     (number),
    .radix      (radix),
    .q_full     (q_full),
    .push       (push),
    .push_count (push_count),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  // Queue of finished digit strings.
  itoa_queue #(
    .CNT_W (CNT_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_count (push_count),
    .pop        (pop),
    .head_count (head_count),
    .nonempty   (q_nonempty),
    .full       (q_full)
  );

  // Two-bank digit store.
  itoa_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (DEPTH)
  ) u_digits (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Character emission.
  itoa_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .head_count (head_count),
    .pop        (pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .text       (text)
  );

endmodule

`default_nettype wire

>>> design/itoa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module itoa_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> design/itoa_front.sv
// Front end: accepts a word and produces its digits, least significant first,
// with an eight-bit-per-cycle restoring divider; writes them to one RAM bank.
// Depends on itoa_pkg and itoa_value_if.
`default_nettype none

module itoa_front import itoa_pkg::*; #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  itoa_value_if.sink                      number,
  input  logic [RADIX_W-1:0]              radix,
  input  logic                            q_full,
  output logic                            push,
  output logic [$clog2(MAX_DIGITS+1)-1:0] push_count,
  output logic                            wr_en,
  output logic [$clog2(MAX_DIGITS):0]     wr_addr,
  output logic [DIGIT_W-1:0]              wr_data
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int CYC   = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int CYC_W = (CYC > 1) ? $clog2(CYC) : 1;
  localparam int PAD_W = CYC * DIV_STEPS;

  front_state_t       state, state_next;
  logic [PAD_W-1:0]   sh, sh_n;
  logic [DIGIT_W-1:0] rem, rem_n;
  logic [CYC_W-1:0]   cyc_cnt;
  logic [CNT_W-1:0]   dcount;
  logic               wbank;
  logic [RADIX_W-1:0] r_eff;
  logic               accept;
  logic               digit_end;
  logic               done;

  // Eight restoring division steps on the shifting dividend/quotient word.
  always_comb begin
    logic [DIGIT_W:0] trial;
    sh_n  = sh;
    rem_n = rem;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {rem_n, sh_n[PAD_W-1]};
      sh_n  = {sh_n[PAD_W-2:0], 1'b0};
      if (trial >= {1'b0, r_eff}) begin
        rem_n   = DIGIT_W'(trial - {1'b0, r_eff});
        sh_n[0] = 1'b1;
      end else begin
        rem_n = DIGIT_W'(trial);
      end
    end
  end

  assign accept    = number.valid && number.ready;
  assign digit_end = (cyc_cnt == CYC_W'(CYC - 1));
  assign done      = (sh_n == '0) || (dcount == CNT_W'(MAX_DIGITS - 1));

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control outputs.
  always_comb begin
    state_next   = state;
    number.ready = 1'b0;
    wr_en        = 1'b0;
    push         = 1'b0;
    unique case (state)
      ST_IDLE: begin
        number.ready = !q_full;
        if (number.valid && !q_full) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (digit_end) begin
          wr_en = 1'b1;
          if (done) begin
            push       = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign wr_addr    = {wbank, dcount[IDX_W-1:0]};
  assign wr_data    = rem_n;
  assign push_count = dcount + CNT_W'(1);

  // Bank pointer toggles each time a finished digit string is queued.
  always_ff @(posedge clk) begin
    if (rst) begin
      wbank <= 1'b0;
    end else if (push) begin
      wbank <= !wbank;
    end
  end

  // Divider datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      sh      <= PAD_W'(VALUE_BITS'(number.value));
      rem     <= '0;
      cyc_cnt <= '0;
      dcount  <= '0;
      r_eff   <= eff_radix(radix);
    end else if (state == ST_DIVIDE) begin
      sh <= sh_n;
      if (digit_end) begin
        rem     <= '0;
        cyc_cnt <= '0;
        dcount  <= dcount + CNT_W'(1);
      end else begin
        rem     <= rem_n;
        cyc_cnt <= cyc_cnt + CYC_W'(1);
      end
    end
  end

  // A digit is never written past the end of its bank.
  a_digit_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> dcount < CNT_W'(MAX_DIGITS))
    else $error("digit written beyond the bank");

  // A word is only taken when a bank is free for its digits.
  a_accept_free_bank: assert property (@(posedge clk) disable iff (rst)
    accept |-> !q_full)
    else $error("word accepted while both banks are in use");

endmodule

`default_nettype wire

>>> design/itoa_queue.sv
// Two-entry queue of digit counts between the converter and the emitter.
// Each entry owns one RAM bank; banks alternate with the entries.
// No dependencies.
`default_nettype none

module itoa_queue #(
  parameter int CNT_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [CNT_W-1:0] push_count,
  input  logic             pop,
  output logic [CNT_W-1:0] head_count,
  output logic             nonempty,
  output logic             full
);

  logic [CNT_W-1:0] slot [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       fill;

  assign head_count = slot[rptr];
  assign nonempty   = (fill != 2'd0);
  assign full       = (fill == 2'd2);

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= push_count;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

>>> design/itoa_back.sv
// Back end: reads a queued digit string from its RAM bank in reverse order
// and presents each digit as an ASCII character in an output register.
// Depends on itoa_pkg and itoa_char_if.
`default_nettype none

module itoa_back import itoa_pkg::*; #(
  parameter int MAX_DIGITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_nonempty,
  input  logic [$clog2(MAX_DIGITS+1)-1:0] head_count,
  output logic                            pop,
  output logic                            rd_en,
  output logic [$clog2(MAX_DIGITS):0]     rd_addr,
  input  logic [DIGIT_W-1:0]              rd_data,
  itoa_char_if.source                     text
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  logic              rbank;
  logic [CNT_W-1:0]  kidx;
  logic              rd_pend;
  logic              rd_last;
  logic              ovalid;
  logic [CHAR_W-1:0] ochar;
  logic              olast;
  logic              out_fire;
  logic              last_issue;
  logic [CNT_W-1:0]  pos;

  assign out_fire   = ovalid && text.ready;
  assign rd_en      = q_nonempty && !rd_pend && (!ovalid || out_fire);
  assign last_issue = (kidx == head_count - CNT_W'(1));
  assign pos        = head_count - CNT_W'(1) - kidx;
  assign rd_addr    = {rbank, pos[IDX_W-1:0]};
  assign pop        = rd_en && last_issue;

  // Read sequencing over the digit string, most significant digit first.
  always_ff @(posedge clk) begin
    if (rst) begin
      rbank   <= 1'b0;
      kidx    <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_en;
      if (rd_en) begin
        if (last_issue) begin
          kidx  <= '0;
          rbank <= !rbank;
        end else begin
          kidx <= kidx + CNT_W'(1);
        end
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (rd_pend) begin
      ovalid <= 1'b1;
    end else if (out_fire) begin
      ovalid <= 1'b0;
    end
  end

  // Output payload, loaded when the RAM data arrives.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_last <= last_issue;
    end
    if (rd_pend) begin
      ochar <= digit_char(rd_data);
      olast <= rd_last;
    end
  end

  assign text.valid     = ovalid;
  assign text.character = ochar;
  assign text.last_char = olast;

  // Arriving RAM data always finds the output register free.
  a_capture_free: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !ovalid)
    else $error("read data overruns the output register");

  // The position counter stays inside the queued string.
  a_index_in_string: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> kidx < head_count)
    else $error("read beyond the queued digit count");

endmodule

`default_nettype wire

>>> bench/tb_radix_integer_to_ascii.sv
// Self-checking testbench for the radix integer-to-ASCII converter.
// Depends on itoa_pkg, itoa_value_if, itoa_char_if and radix_integer_to_ascii.
// Words go in through a randomly paced driver; characters are checked against a digit predictor.
`default_nettype none

module tb_radix_integer_to_ascii import itoa_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // One expected character of the text stream.
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last_char;
  } glyph_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic radix_wr_en = 1'b0;
  logic [RADIX_W-1:0] radix_wr_data = '0;

  itoa_value_if number_ch ();
  itoa_char_if  text_ch ();

  radix_integer_to_ascii dut (
    .clk           (clk),
    .rst           (rst),
    .radix_wr_en   (radix_wr_en),
    .radix_wr_data (radix_wr_data),
    .number        (number_ch),
    .text          (text_ch)
  );

  // Words waiting to be offered, and characters waiting to come out.
  logic [IN_W-1:0] pending_words[$];
  glyph_t          expected_glyphs[$];

  logic [RADIX_W-1:0] radix_mirror = RADIX_W'(RADIX_RESET);
  bit                 quiet = 1'b0;
  int                 mismatches = 0;
  int                 word_gap = 0;
  int                 text_stall = 0;

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Pause length for one request; zero in quiet phases and often otherwise.
  function automatic int draw_pause();
    if (quiet || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  task automatic note_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Works out the characters of one word in the current radix, most significant first.
  function automatic void queue_digits(input logic [IN_W-1:0] word);
    logic [IN_W-1:0]    rest;
    logic [DIGIT_W-1:0] digits[IN_W];
    logic [RADIX_W-1:0] base;
    int                 count;
    glyph_t             g;
    base = radix_mirror;
    if (base < RADIX_W'(RADIX_MIN)) begin
      base = RADIX_W'(RADIX_MIN);
    end else if (base > RADIX_W'(RADIX_MAX)) begin
      base = RADIX_W'(RADIX_MAX);
    end
    rest = word;
    count = 0;
    if (rest == '0) begin
      digits[0] = '0;
      count = 1;
    end
    while (rest != '0 && count < IN_W) begin
      digits[count] = DIGIT_W'(rest % base);
      rest = rest / base;
      count++;
    end
    for (int k = count - 1; k >= 0; k--) begin
      if (digits[k] >= DIGIT_W'(DECIMAL)) begin
        g.character = CHAR_W'(digits[k] - DECIMAL + ASCII_A);
      end else begin
        g.character = CHAR_W'(digits[k] + ASCII_ZERO);
      end
      g.last_char = (k == 0);
      expected_glyphs.push_back(g);
    end
  endfunction

  // Word driver: predicts on each accepted request, then waits its drawn gap.
  always @(posedge clk) begin
    int wait_n;
    if (rst) begin
      number_ch.valid <= 1'b0;
      number_ch.value <= '0;
      word_gap <= 0;
    end else if (!number_ch.valid || number_ch.ready) begin
      wait_n = word_gap;
      if (number_ch.valid) begin
        queue_digits(number_ch.value);
        wait_n = draw_pause();
      end
      if (wait_n != 0) begin
        number_ch.valid <= 1'b0;
        word_gap <= wait_n - 1;
      end else if (pending_words.size() != 0) begin
        number_ch.valid <= 1'b1;
        number_ch.value <= pending_words.pop_front();
        word_gap <= 0;
      end else begin
        number_ch.valid <= 1'b0;
        word_gap <= 0;
      end
    end
  end

  // Character monitor: checks each accepted request and stalls at random.
  always @(posedge clk) begin
    int     wait_n;
    glyph_t want;
    if (rst) begin
      text_ch.ready <= 1'b0;
      text_stall <= 0;
    end else begin
      wait_n = text_stall;
      if (text_ch.valid && text_ch.ready) begin
        if (expected_glyphs.size() == 0) begin
          note_mismatch($sformatf("unexpected character 0x%0h", text_ch.character));
        end else begin
          want = expected_glyphs.pop_front();
          if (text_ch.character !== want.character) begin
            note_mismatch($sformatf("character 0x%0h, want 0x%0h",
                                    text_ch.character, want.character));
          end
          if (text_ch.last_char !== want.last_char) begin
            note_mismatch($sformatf("last_char %b, want %b (character 0x%0h)",
                                    text_ch.last_char, want.last_char, want.character));
          end
        end
        wait_n = draw_pause();
      end
      if (wait_n != 0) begin
        text_ch.ready <= 1'b0;
        text_stall <= wait_n - 1;
      end else begin
        text_ch.ready <= 1'b1;
        text_stall <= 0;
      end
    end
  end

  // Waits until every word is taken and every character has come out.
  task automatic drain();
    do begin
      @(posedge clk);
    end while (pending_words.size() != 0 || number_ch.valid || expected_glyphs.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Radix writes happen only with the converter idle.
  task automatic set_radix(input logic [RADIX_W-1:0] r);
    drain();
    radix_wr_en <= 1'b1;
    radix_wr_data <= r;
    radix_mirror = r;
    @(posedge clk);
    radix_wr_en <= 1'b0;
  endtask

  task automatic offer(input logic [IN_W-1:0] word);
    @(negedge clk);
    pending_words.push_back(word);
  endtask

  // Random word: full range, short numbers, or a random bit length.
  function automatic logic [IN_W-1:0] random_word();
    case ($urandom_range(0, 3))
      0: return IN_W'($urandom_range(0, 50));
      1: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Stimulus: directed words per radix, then random phases.
  initial begin
    logic [RADIX_W-1:0] phase_radix[10];
    phase_radix = '{6'd10, 6'd16, 6'd2, 6'd36, 6'd0, 6'd63, 6'd1, 6'd37, 6'd3, 6'd7};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Decimal out of reset: zero, single digits, the largest word, top bit.
    offer(32'd0);
    offer(32'd1);
    offer(32'd9);
    offer(32'd10);
    offer(32'hFFFF_FFFF);
    offer(32'h8000_0000);
    offer(32'd1000000000);
    offer(32'd999999999);

    // Largest radix reaches 'Z'.
    set_radix(6'd36);
    offer(32'd35);
    offer(32'd36);
    offer(32'd0);
    offer(32'hFFFF_FFFF);

    // Binary gives the full 32 digits.
    set_radix(6'd2);
    offer(32'hFFFF_FFFF);
    offer(32'd1);
    offer(32'h8000_0000);

    // Radix below two acts as binary, above thirty-six as base 36.
    set_radix(6'd0);
    offer(32'd5);
    set_radix(6'd1);
    offer(32'd6);
    set_radix(6'd63);
    offer(32'd35);
    set_radix(6'd37);
    offer(32'd71);

    // Random phases, some with no idling on either side.
    for (int p = 0; p < 11; p++) begin
      set_radix(p < 10 ? phase_radix[p] : RADIX_W'($urandom_range(0, 63)));
      quiet = (p % 3 == 2);
      for (int n = 0; n < 28; n++) begin
        offer(random_word());
      end
    end
    drain();
    quiet = 1'b0;

    if (mismatches == 0) begin
      $display("tb_radix_integer_to_ascii: PASS");
    end else begin
      $display("tb_radix_integer_to_ascii: FAIL");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #8ms;
    $display("tb_radix_integer_to_ascii: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
